// ===== rtl/lruc_pkg.sv =====
package lruc_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 64;
    localparam int REQ_W     = 64;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int OUT_W     = 8;
    localparam int CAP_RESET = 64;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        logic key_we;
        logic rank_we;
        idx_t addr;
        key_t key;
        idx_t rank;
    } lruc_wr_t;

endpackage

// ===== rtl/lru_cache_hit_tracker.sv =====
// Fully associative LRU directory of 64 keys. Each request on the slave stream
// carries one key and produces one response whose bit 0 is set on a hit. A hit
// makes the entry the most recently used; a miss first evicts every entry that
// no longer fits under the capacity register, then stores the key as most
// recently used in the lowest free slot. The key and recency stores each have a
// single read port, so a request walks all 64 slots twice, once to look for the
// key and once to age, promote or evict entries; a miss then adds an insert step.
// The response appears in the same cycle in which the next request can be taken,
// and s_axis_tready stays low until then. A finished response waits in its output
// register and does not stop the next request from being taken, but that next
// request holds its own response until the register is free. The capacity
// register accepts 1 to 64; 0 acts as 1 and larger values act as 64. Lowering it
// takes effect on the next miss.
module lru_cache_hit_tracker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lruc_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [lruc_pkg::REQ_W-1:0] s_axis_tdata,   // [63:0] request_key
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [lruc_pkg::OUT_W-1:0] m_axis_tdata    // [0] hit, [7:1] zero
);
    import lruc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_INSERT,
        ST_DONE
    } state_t;

    localparam idx_t LAST_IDX = idx_t'(CAPACITY - 1);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cap_cfg_reg, cap_cfg_next;
    key_t                key_reg, key_next;
    idx_t                cap_m1_reg, cap_m1_next;
    logic                hit_reg, hit_next;
    idx_t                hit_idx_reg, hit_idx_next;
    idx_t                hit_rank_reg, hit_rank_next;
    logic                free_found_reg, free_found_next;
    idx_t                free_idx_reg, free_idx_next;
    idx_t                addr_reg, addr_next;
    logic                run_reg, run_next;
    logic                pipe_vld_reg, pipe_vld_next;
    idx_t                pipe_idx_reg, pipe_idx_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;

    logic [CMP_W-1:0]    cap_ext;
    idx_t                cap_m1_calc;
    lruc_wr_t            wr;
    key_t                rd_key;
    idx_t                rd_rank;
    logic                entry_valid;
    logic                s_accept;

    lruc_store u_store (
        .aclk    (aclk),
        .rd_addr (addr_reg),
        .wr      (wr),
        .rd_key  (rd_key),
        .rd_rank (rd_rank)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - 1){1'b0}}, m_hit_reg};
    assign entry_valid   = valid_reg[pipe_idx_reg];

    always_comb begin
        cap_ext = CMP_W'(cap_cfg_reg);
        if (cap_ext == '0) begin
            cap_m1_calc = '0;
        end else if (cap_ext > CMP_W'(CAPACITY)) begin
            cap_m1_calc = LAST_IDX;
        end else begin
            cap_m1_calc = idx_t'(cap_ext - CMP_W'(1));
        end
    end

    always_comb begin
        state_next      = state_reg;
        cap_cfg_next    = cfg_wr_en ? cfg_wr_data : cap_cfg_reg;
        key_next        = key_reg;
        cap_m1_next     = cap_m1_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        addr_next       = addr_reg;
        run_next        = run_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_hit_next      = m_hit_reg;
        wr              = '0;

        if ((state_reg == ST_SCAN || state_reg == ST_UPDATE) && run_reg) begin
            pipe_vld_next = 1'b1;
            pipe_idx_next = addr_reg;
            addr_next     = addr_reg + idx_t'(1);
            if (addr_reg == LAST_IDX) begin
                run_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    key_next        = s_axis_tdata[KEY_WIDTH-1:0];
                    cap_m1_next     = cap_m1_calc;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    addr_next       = '0;
                    run_next        = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pipe_vld_reg) begin
                    if (entry_valid && rd_key == key_reg) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = pipe_idx_reg;
                        hit_rank_next = rd_rank;
                    end
                    if (pipe_idx_reg == LAST_IDX) begin
                        addr_next  = '0;
                        run_next   = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (pipe_vld_reg) begin
                    wr.addr = pipe_idx_reg;
                    if (hit_reg) begin
                        if (pipe_idx_reg == hit_idx_reg) begin
                            wr.rank_we = 1'b1;
                            wr.rank    = '0;
                        end else if (entry_valid && rd_rank < hit_rank_reg) begin
                            wr.rank_we = 1'b1;
                            wr.rank    = rd_rank + idx_t'(1);
                        end
                    end else begin
                        if (entry_valid && rd_rank < cap_m1_reg) begin
                            wr.rank_we = 1'b1;
                            wr.rank    = rd_rank + idx_t'(1);
                        end else begin
                            valid_next[pipe_idx_reg] = 1'b0;
                            if (!free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = pipe_idx_reg;
                            end
                        end
                    end
                    if (pipe_idx_reg == LAST_IDX) begin
                        state_next = hit_reg ? ST_DONE : ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                wr.key_we               = 1'b1;
                wr.rank_we              = 1'b1;
                wr.addr                 = free_idx_reg;
                wr.key                  = key_reg;
                wr.rank                 = '0;
                valid_next[free_idx_reg] = 1'b1;
                state_next              = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_cfg_reg  <= CFG_W'(CAP_RESET);
            run_reg      <= 1'b0;
            pipe_vld_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_hit_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_cfg_reg  <= cap_cfg_next;
            run_reg      <= run_next;
            pipe_vld_reg <= pipe_vld_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
            m_hit_reg    <= m_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        cap_m1_reg     <= cap_m1_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        addr_reg       <= addr_next;
        pipe_idx_reg   <= pipe_idx_next;
    end

endmodule

// ===== rtl/lruc_store.sv =====
module lruc_store (
    input  logic             aclk,
    input  lruc_pkg::idx_t   rd_addr,
    input  lruc_pkg::lruc_wr_t wr,
    output lruc_pkg::key_t   rd_key,
    output lruc_pkg::idx_t   rd_rank
);
    import lruc_pkg::*;

    key_t key_mem [CAPACITY];
    idx_t rank_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.key_we) begin
            key_mem[wr.addr] <= wr.key;
        end
        rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.rank_we) begin
            rank_mem[wr.addr] <= wr.rank;
        end
        rd_rank <= rank_mem[rd_addr];
    end

endmodule

// ===== rtl/lruc_checker.sv =====
module lruc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [lruc_pkg::OUT_W-1:0] m_axis_tdata
);
    import lruc_pkg::*;

    logic s_accept;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // A response that is not taken stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response changed while stalled");

    // The directory walk keeps the block busy after a request is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request taken while a lookup was in progress");

    // A new response only appears at the end of a lookup.
    a_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("response without a lookup in progress");

    // Only the hit flag carries information.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:1] == '0)
        else $error("padding bits of the response are not zero");

endmodule

bind lru_cache_hit_tracker lruc_checker u_lruc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/lru_cache_hit_tracker_checker.sv =====
`timescale 1ns / 1ps

module lru_cache_hit_tracker_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lruc_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [lruc_pkg::REQ_W-1:0] s_axis_tdata,   // [63:0] request_key
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [lruc_pkg::OUT_W-1:0] m_axis_tdata,   // [0] hit, [7:1] zero
    output int unsigned                mismatches,
    output int unsigned                responses,
    output int unsigned                hits,
    output int unsigned                pending
);
    import lruc_pkg::*;

    key_t             dir_key   [CAPACITY];
    logic             dir_valid [CAPACITY];
    idx_t             dir_rank  [CAPACITY];
    logic [CNT_W-1:0] dir_count;
    logic [CFG_W-1:0] capacity_reg;
    logic [OUT_W-1:0] expected_resp [$];

    function automatic logic lru_access(input key_t key);
        int   i;
        int   j;
        int   eff;
        idx_t r;
        eff = int'(capacity_reg);
        if (eff < 1) begin
            eff = 1;
        end
        if (eff > CAPACITY) begin
            eff = CAPACITY;
        end
        for (i = 0; i < CAPACITY; i++) begin
            if (dir_valid[i] && dir_key[i] == key) begin
                r = dir_rank[i];
                for (j = 0; j < CAPACITY; j++) begin
                    if (dir_valid[j] && dir_rank[j] < r) begin
                        dir_rank[j]++;
                    end
                end
                dir_rank[i] = '0;
                return 1'b1;
            end
        end
        // On a miss the least recently used entries go first, until the key fits.
        while (int'(dir_count) >= eff && dir_count > 0) begin
            for (i = 0; i < CAPACITY; i++) begin
                if (dir_valid[i] && CNT_W'(dir_rank[i]) + CNT_W'(1) == dir_count) begin
                    dir_valid[i] = 1'b0;
                    dir_count--;
                    break;
                end
            end
        end
        for (i = 0; i < CAPACITY; i++) begin
            if (dir_valid[i]) begin
                dir_rank[i]++;
            end
        end
        for (i = 0; i < CAPACITY; i++) begin
            if (!dir_valid[i]) begin
                dir_valid[i] = 1'b1;
                dir_key[i]   = key;
                dir_rank[i]  = '0;
                dir_count++;
                break;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                   input logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0d at %0t ns: %s, expected %h, actual %h",
                     mismatches, $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        int               i;
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            for (i = 0; i < CAPACITY; i++) begin
                dir_valid[i] = 1'b0;
            end
            dir_count    = '0;
            capacity_reg = CFG_W'(CAP_RESET);
            expected_resp.delete();
            mismatches = 0;
            responses  = 0;
            hits       = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                responses++;
                hits += int'(m_axis_tdata[0]);
                if (expected_resp.size() == 0) begin
                    report_mismatch("response with no request waiting", 'x, m_axis_tdata);
                end else begin
                    want = expected_resp.pop_front();
                    if (m_axis_tdata !== want) begin
                        report_mismatch("hit flag", want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resp.push_back(OUT_W'(lru_access(s_axis_tdata[KEY_WIDTH-1:0])));
            end
            if (cfg_wr_en) begin
                capacity_reg = cfg_wr_data;
            end
        end
        pending = expected_resp.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lruc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 800;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 100;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [REQ_W-1:0] s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    int unsigned mismatches;
    int unsigned responses;
    int unsigned hits;
    int unsigned pending;
    int unsigned requests_sent;
    int unsigned settings_used;
    int unsigned cycle_count = 0;
    bit          quiet;
    bit          hold_request;
    key_t        key_pool [$];

    lru_cache_hit_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lru_cache_hit_tracker_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .responses     (responses),
        .hits          (hits),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic key_t random_key();
        return {$urandom, $urandom};
    endfunction

    task automatic issue_lookup(input key_t key);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = key;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_responses();
        while (responses != requests_sent) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] value);
        s_axis_tvalid = 1'b0;
        drain_responses();
        repeat (4) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        settings_used++;
    endtask

    initial begin : response_sink
        int unsigned stall_left;
        bit          hold_done;
        stall_left    = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                // A long hold on the response side backs requests up into the block.
                hold_done     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 16);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        key_t        k1;
        key_t        k2;
        key_t        k3;
        key_t        k4;
        int unsigned phase;
        int unsigned n;
        int unsigned pick;
        int unsigned cap_value;
        int unsigned eff;
        int unsigned pool_size;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        requests_sent = 0;
        settings_used = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        issue_lookup('0);
        issue_lookup('1);
        issue_lookup('0);
        issue_lookup('1);
        issue_lookup(key_t'(1));
        issue_lookup('0);

        k1 = random_key();
        k2 = ~k1;
        k3 = random_key();
        k4 = k3 ^ (key_t'(1) << (KEY_WIDTH - 1));
        set_capacity(CFG_W'(1));
        issue_lookup(k1);
        issue_lookup(k1);
        issue_lookup(k2);
        issue_lookup(k1);
        set_capacity(CFG_W'(0));
        issue_lookup(k3);
        issue_lookup(k3);
        issue_lookup(k4);
        issue_lookup(k3);
        set_capacity(CFG_W'(3));
        issue_lookup(k1);
        issue_lookup(k2);
        issue_lookup(k3);
        issue_lookup(k1);
        set_capacity(CFG_W'(2));
        issue_lookup(k2);
        issue_lookup(k4);
        issue_lookup(k1);
        issue_lookup(k2);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       cap_value = 64;
                1:       cap_value = 127;
                2:       cap_value = 1;
                3:       cap_value = 0;
                4:       cap_value = 2;
                5:       cap_value = 7;
                6:       cap_value = 33;
                7:       cap_value = 63;
                8:       cap_value = 65;
                11:      cap_value = 64;
                default: cap_value = $urandom_range(0, 127);
            endcase
            quiet = (phase >= PHASES - 2);
            set_capacity(CFG_W'(cap_value));
            eff = (cap_value < 1) ? 1 : (cap_value > CAPACITY) ? CAPACITY : cap_value;
            pool_size = eff + $urandom_range(0, eff / 2 + 2);
            key_pool.delete();
            repeat (pool_size) key_pool.push_back(random_key());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 40) begin
                    hold_request = 1'b1;
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    issue_lookup(random_key());
                end else if (pick == 1) begin
                    issue_lookup(key_pool[$urandom_range(0, pool_size - 1)] ^
                                 (key_t'(1) << $urandom_range(0, KEY_WIDTH - 1)));
                end else begin
                    issue_lookup(key_pool[$urandom_range(0, pool_size - 1)]);
                end
            end
        end

        s_axis_tvalid = 1'b0;
        drain_responses();
        repeat (300) @(negedge aclk);
        $display("Sent %0d requests under %0d capacity settings, from 0 and 1 up to 64 and 127.",
                 requests_sent, settings_used);
        $display("Checked %0d responses (%0d hits), %0d mismatches, %0d still expected.",
                 responses, hits, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lruc_pkg.sv
rtl/lruc_store.sv
rtl/lru_cache_hit_tracker.sv
rtl/lruc_checker.sv
tb/sv/lru_cache_hit_tracker_checker.sv
tb/sv/tb.sv
